// ----- src/sld_pkg.sv -----
// Shared types, constants and address helpers for the screen depacker.
// Used by screen_lz_rle_depacker_top and sld_checker; depends on nothing.

package sld_pkg;

    localparam int PIXEL_BYTES  = 6144;
    localparam int ATTR_BYTES   = 768;
    localparam int SCREEN_BYTES = PIXEL_BYTES + ATTR_BYTES;
    localparam int ADDR_W       = $clog2(SCREEN_BYTES);
    localparam int BYTE_W       = 8;
    localparam int RUN_W        = 7;
    localparam int SRC_W        = 16;

    localparam logic [1:0] KIND_PACKED = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_START  = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_DONE = 2'd1;
    localparam logic [1:0] STATUS_ERR  = 2'd2;

    localparam logic [7:0] CMD_END       = 8'h80;
    localparam logic [7:0] CMD_CLASS     = 8'hc0;
    localparam logic [7:0] CMD_LITERAL   = 8'h80;
    localparam logic [7:0] CMD_FILL      = 8'hc0;
    localparam logic [7:0] RUN_MASK      = 8'h3f;
    localparam logic [7:0] REF_LEN_MASK  = 8'hf8;
    localparam logic [7:0] REF_HI_MASK   = 8'h07;
    localparam logic [6:0] MIN_RUN       = 7'd3;

    localparam logic [7:0] PIXEL_INIT = 8'h00;
    localparam logic [7:0] ATTR_INIT  = 8'h07;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [1:0] {
        PH_CMD,
        PH_LITERAL,
        PH_FILL,
        PH_DIST
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_READ
    } ctl_state_t;

    // linear position -> store address (third | line | row | column)
    function automatic addr_t map_addr(addr_t v);
        addr_t a;
        if (v < ADDR_W'(PIXEL_BYTES))
            a = {v[12:11], v[2:0], v[5:3], v[10:6]};
        else
            a = v;
        return a;
    endfunction

    // store address -> linear position
    function automatic addr_t unmap_addr(addr_t a);
        addr_t v;
        if (a < ADDR_W'(PIXEL_BYTES))
            v = {a[12:11], a[4:0], a[7:5], a[10:8]};
        else
            v = a;
        return v;
    endfunction

endpackage

// ----- src/sld_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.

module sld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// ----- src/screen_lz_rle_depacker_top.sv -----
// Screen LZ/RLE depacker: decodes one packed screen into a 6912-byte store.
// Command, literal, start, status and out-of-range read items answer from ST_IDLE;
// an in-range read uses ST_READ; a fill (up to 66 bytes) runs in ST_FILL; a back-reference
// alternates ST_COPY_RD/ST_COPY_WR. One read, one write port; a fill writes a byte a cycle.
// Reset clears control state only; unwritten store bytes read as 0 / 7.
// Results cannot be stalled; a new item may start in the result cycle.
// Depends on sld_pkg and sld_ram.

module screen_lz_rle_depacker_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [7:0]  packed_byte,
    input  logic [12:0] read_address,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  read_data
);

    sld_pkg::ctl_state_t state_reg, state_next;
    sld_pkg::phase_t     phase_reg, phase_next;
    sld_pkg::addr_t      pos_reg, pos_next;
    logic [sld_pkg::RUN_W-1:0] run_reg, run_next;
    logic [2:0]          dhi_reg, dhi_next;
    logic                err_reg, err_next;
    logic                fin_reg, fin_next;
    sld_pkg::byte_t      fill_reg, fill_next;
    logic [sld_pkg::SRC_W-1:0] src_reg, src_next;
    logic                hit_reg, hit_next;
    logic                attr_reg, attr_next;
    logic                done_reg, done_next;
    logic [1:0]          status_reg, status_next;
    sld_pkg::byte_t      rdata_reg, rdata_next;

    logic                ram_we;
    sld_pkg::addr_t      ram_waddr;
    sld_pkg::byte_t      ram_wdata;
    logic                ram_re;
    sld_pkg::addr_t      ram_raddr;
    sld_pkg::byte_t      ram_rdata;

    logic                accept;
    logic                pos_full;
    logic                src_bad;
    logic                rd_in_range;
    logic                last_run;
    sld_pkg::byte_t      background;
    logic                finish;
    logic                read_done;
    logic                read_bad;

    assign accept      = start && (state_reg == sld_pkg::ST_IDLE);
    assign pos_full    = pos_reg >= sld_pkg::ADDR_W'(sld_pkg::SCREEN_BYTES);
    assign src_bad     = src_reg >= sld_pkg::SRC_W'(sld_pkg::SCREEN_BYTES);
    assign rd_in_range = read_address < sld_pkg::ADDR_W'(sld_pkg::SCREEN_BYTES);
    assign last_run    = run_reg == sld_pkg::RUN_W'(1);
    assign background  = attr_reg ? sld_pkg::ATTR_INIT : sld_pkg::PIXEL_INIT;

    sld_ram #(
        .WIDTH (sld_pkg::BYTE_W),
        .DEPTH (sld_pkg::SCREEN_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sld_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == sld_pkg::KIND_PACKED && !err_reg && !fin_reg)
                    begin
                        if (phase_reg == sld_pkg::PH_FILL)
                            state_next = sld_pkg::ST_FILL;
                        else if (phase_reg == sld_pkg::PH_DIST)
                            state_next = sld_pkg::ST_COPY_RD;
                    end
                    else if (kind == sld_pkg::KIND_READ && rd_in_range)
                        state_next = sld_pkg::ST_READ;
                end
            end
            sld_pkg::ST_FILL:
            begin
                if (pos_full || last_run)
                    state_next = sld_pkg::ST_IDLE;
            end
            sld_pkg::ST_COPY_RD:
            begin
                if (src_bad)
                    state_next = sld_pkg::ST_IDLE;
                else
                    state_next = sld_pkg::ST_COPY_WR;
            end
            sld_pkg::ST_COPY_WR:
            begin
                if (pos_full || last_run)
                    state_next = sld_pkg::ST_IDLE;
                else
                    state_next = sld_pkg::ST_COPY_RD;
            end
            sld_pkg::ST_READ:
                state_next = sld_pkg::ST_IDLE;
            default:
                state_next = sld_pkg::ST_IDLE;
        endcase
    end

    // datapath, store access and results
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        run_next    = run_reg;
        dhi_next    = dhi_reg;
        err_next    = err_reg;
        fin_next    = fin_reg;
        fill_next   = fill_reg;
        src_next    = src_reg;
        hit_next    = hit_reg;
        attr_next   = attr_reg;
        status_next = status_reg;
        rdata_next  = rdata_reg;
        ram_we      = 1'b0;
        ram_waddr   = sld_pkg::map_addr(pos_reg);
        ram_wdata   = fill_reg;
        ram_re      = 1'b0;
        ram_raddr   = read_address;
        finish      = 1'b0;
        read_done   = 1'b0;
        read_bad    = 1'b0;

        unique case (state_reg)
            sld_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        sld_pkg::KIND_PACKED:
                        begin
                            if (err_reg)
                                finish = 1'b1;
                            else if (fin_reg)
                            begin
                                err_next = 1'b1;
                                finish   = 1'b1;
                            end
                            else
                            begin
                                unique case (phase_reg)
                                    sld_pkg::PH_LITERAL:
                                    begin
                                        finish = 1'b1;
                                        if (pos_full)
                                            err_next = 1'b1;
                                        else
                                        begin
                                            ram_we    = 1'b1;
                                            ram_wdata = packed_byte;
                                            pos_next  = pos_reg + sld_pkg::ADDR_W'(1);
                                            run_next  = run_reg - sld_pkg::RUN_W'(1);
                                            if (last_run)
                                                phase_next = sld_pkg::PH_CMD;
                                        end
                                    end
                                    sld_pkg::PH_FILL:
                                        fill_next = packed_byte;
                                    sld_pkg::PH_DIST:
                                        src_next = {3'b000, pos_reg}
                                                 - {5'b00000, dhi_reg, packed_byte};
                                    default:
                                    begin
                                        finish = 1'b1;
                                        if (packed_byte == sld_pkg::CMD_END)
                                        begin
                                            if (pos_reg == sld_pkg::ADDR_W'(sld_pkg::SCREEN_BYTES))
                                                fin_next = 1'b1;
                                            else
                                                err_next = 1'b1;
                                        end
                                        else if ((packed_byte & sld_pkg::CMD_CLASS)
                                                 == sld_pkg::CMD_LITERAL)
                                        begin
                                            run_next   = 7'(packed_byte & sld_pkg::RUN_MASK);
                                            phase_next = sld_pkg::PH_LITERAL;
                                        end
                                        else if ((packed_byte & sld_pkg::CMD_CLASS)
                                                 == sld_pkg::CMD_FILL)
                                        begin
                                            run_next   = 7'(packed_byte & sld_pkg::RUN_MASK)
                                                       + sld_pkg::MIN_RUN;
                                            phase_next = sld_pkg::PH_FILL;
                                        end
                                        else
                                        begin
                                            run_next   = 7'((packed_byte & sld_pkg::REF_LEN_MASK)
                                                            >> 3) + sld_pkg::MIN_RUN;
                                            dhi_next   = 3'(packed_byte & sld_pkg::REF_HI_MASK);
                                            phase_next = sld_pkg::PH_DIST;
                                        end
                                    end
                                endcase
                            end
                        end
                        sld_pkg::KIND_READ:
                        begin
                            if (rd_in_range)
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = read_address;
                                // written in this image iff its position is behind the writer
                                hit_next  = sld_pkg::unmap_addr(read_address) < pos_reg;
                                attr_next = read_address
                                            >= sld_pkg::ADDR_W'(sld_pkg::PIXEL_BYTES);
                            end
                            else
                                read_bad = 1'b1;
                        end
                        sld_pkg::KIND_START:
                        begin
                            finish     = 1'b1;
                            phase_next = sld_pkg::PH_CMD;
                            pos_next   = '0;
                            run_next   = '0;
                            dhi_next   = '0;
                            err_next   = 1'b0;
                            fin_next   = 1'b0;
                        end
                        default:
                            finish = 1'b1;
                    endcase
                end
            end
            sld_pkg::ST_FILL:
            begin
                if (pos_full)
                begin
                    err_next = 1'b1;
                    finish   = 1'b1;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = fill_reg;
                    pos_next  = pos_reg + sld_pkg::ADDR_W'(1);
                    run_next  = run_reg - sld_pkg::RUN_W'(1);
                    if (last_run)
                    begin
                        phase_next = sld_pkg::PH_CMD;
                        finish     = 1'b1;
                    end
                end
            end
            sld_pkg::ST_COPY_RD:
            begin
                if (src_bad)
                begin
                    err_next = 1'b1;
                    finish   = 1'b1;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = sld_pkg::map_addr(src_reg[sld_pkg::ADDR_W-1:0]);
                    hit_next  = src_reg[sld_pkg::ADDR_W-1:0] < pos_reg;
                    attr_next = src_reg[sld_pkg::ADDR_W-1:0]
                                >= sld_pkg::ADDR_W'(sld_pkg::PIXEL_BYTES);
                end
            end
            sld_pkg::ST_COPY_WR:
            begin
                // read and write alternate, so a distance of one sees the last write
                if (pos_full)
                begin
                    err_next = 1'b1;
                    finish   = 1'b1;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = hit_reg ? ram_rdata : background;
                    pos_next  = pos_reg + sld_pkg::ADDR_W'(1);
                    src_next  = src_reg + sld_pkg::SRC_W'(1);
                    run_next  = run_reg - sld_pkg::RUN_W'(1);
                    if (last_run)
                    begin
                        dhi_next   = '0;
                        phase_next = sld_pkg::PH_CMD;
                        finish     = 1'b1;
                    end
                end
            end
            sld_pkg::ST_READ:
                read_done = 1'b1;
            default:
                finish = 1'b0;
        endcase

        done_next = finish || read_done || read_bad;
        if (read_done)
        begin
            status_next = sld_pkg::STATUS_OK;
            rdata_next  = hit_reg ? ram_rdata : background;
        end
        else if (read_bad)
        begin
            status_next = sld_pkg::STATUS_ERR;
            rdata_next  = '0;
        end
        else if (finish)
        begin
            if (err_next)
                status_next = sld_pkg::STATUS_ERR;
            else if (fin_next)
                status_next = sld_pkg::STATUS_DONE;
            else
                status_next = sld_pkg::STATUS_OK;
            rdata_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sld_pkg::ST_IDLE;
            phase_reg  <= sld_pkg::PH_CMD;
            pos_reg    <= '0;
            run_reg    <= '0;
            dhi_reg    <= '0;
            err_reg    <= 1'b0;
            fin_reg    <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= sld_pkg::STATUS_OK;
            rdata_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            run_reg    <= run_next;
            dhi_reg    <= dhi_next;
            err_reg    <= err_next;
            fin_reg    <= fin_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            rdata_reg  <= rdata_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_reg <= fill_next;
        src_reg  <= src_next;
        hit_reg  <= hit_next;
        attr_reg <= attr_next;
    end

    assign busy      = state_reg != sld_pkg::ST_IDLE;
    assign done      = done_reg;
    assign status    = status_reg;
    assign read_data = rdata_reg;

endmodule

// ----- src/sld_checker.sv -----
// Port-level checks for screen_lz_rle_depacker_top, bound to every instance.
// Depends on sld_pkg.

module sld_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  kind,
    input logic [7:0]  packed_byte,
    input logic [12:0] read_address,
    input logic        done,
    input logic [1:0]  status,
    input logic [7:0]  read_data
);

    // a result only shows once the block has gone idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an accepted item either finishes at once or holds the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item neither busy nor answered");

    // start item answers next cycle with a clean status
    a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == sld_pkg::KIND_START) |=>
            (done && status == sld_pkg::STATUS_OK && read_data == 8'h00))
        else $error("start item result wrong");

    // data only comes back with a good read
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && read_data != 8'h00) |-> (status == sld_pkg::STATUS_OK))
        else $error("read data with non-ok status");

    // a read beyond the store answers at once with an error
    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == sld_pkg::KIND_READ && read_address >= 13'd6912) |=>
            (done && status == sld_pkg::STATUS_ERR))
        else $error("out of range read not flagged");

endmodule

bind screen_lz_rle_depacker_top sld_checker u_sld_checker (.*);
